/* sv/sbb_pkg.sv */
// ============================================================================
// sbb_pkg: shared types, widths and helpers for the shape bounding box
// Fixed-point formats, shape type codes and rounding/saturation helpers
// used by every pipeline stage.
// ============================================================================
package sbb_pkg;

    // Field formats
    localparam int POS_W          = 32;   // signed Q16.16 position / corner
    localparam int QUAT_W         = 16;   // signed Q2.14 quaternion part
    localparam int SIZE_W         = 31;   // unsigned Q15.16 size
    localparam int QUAT_FRAC_BITS = 14;

    // Internal widths
    localparam int QPROD_W  = 2 * QUAT_W;                 // quaternion product
    localparam int M_W      = QPROD_W + 3;                // matrix entry, 2*QF fraction
    localparam int ABS_W    = QPROD_W + 3 - QUAT_FRAC_BITS - 2; // rounded |Rij|
    localparam int PROD_W   = ABS_W + SIZE_W;             // |Rij| * size
    localparam int SUM_W    = PROD_W + 2;                 // sum of three products
    localparam int EXT_W    = SUM_W - QUAT_FRAC_BITS;     // extent in position format
    localparam int CORNER_W = EXT_W + 2;                  // position +/- extent

    localparam int NUM_STAGES = 5;

    typedef enum logic [1:0] {
        SHAPE_SPHERE  = 2'd0,
        SHAPE_BOX     = 2'd1,
        SHAPE_CAPSULE = 2'd2,
        SHAPE_OTHER   = 2'd3
    } shape_t;

    typedef logic [2:0][POS_W-1:0]         pos_vec_t;
    typedef logic [2:0][SIZE_W-1:0]        size_vec_t;
    typedef logic [2:0][2:0][ABS_W-1:0]    abs_mat_t;
    typedef logic [2:0][2:0][PROD_W-1:0]   prod_mat_t;
    typedef logic [2:0][EXT_W-1:0]         ext_vec_t;

    // |m| rounded half up to QUAT_FRAC_BITS fraction bits
    function automatic logic [ABS_W-1:0] abs_round(input logic signed [M_W-1:0] m);
        logic [M_W-1:0] mag;
        logic [M_W-1:0] rnd;
        mag = m[M_W-1] ? M_W'(-m) : M_W'(m);
        rnd = mag + (M_W'(1) << (QUAT_FRAC_BITS - 1));
        return rnd[QUAT_FRAC_BITS +: ABS_W];
    endfunction

    // Clamp a wide signed value to the signed position range
    function automatic logic [POS_W-1:0] sat_pos(input logic signed [CORNER_W-1:0] v);
        logic hi_same;
        hi_same = (v[CORNER_W-1:POS_W-1] == '0) || (v[CORNER_W-1:POS_W-1] == '1);
        if (hi_same) begin
            return v[POS_W-1:0];
        end else if (v[CORNER_W-1]) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

endpackage

/* sv/sbb_rot.sv */
// ============================================================================
// sbb_rot: rotation matrix stages
// Stage 1 forms the quaternion products, stage 2 builds the matrix entries
// and rounds their magnitudes. Position, sizes and type travel alongside.
// ============================================================================
module sbb_rot
    import sbb_pkg::*;
(
    input  logic                     aclk,
    input  logic [1:0]               adv,       // stage advance: [0] stage 1, [1] stage 2
    input  shape_t                   cmd_in,
    input  pos_vec_t                 pos_in,
    input  size_vec_t                size_in,
    input  logic signed [QUAT_W-1:0] rot_w,
    input  logic signed [QUAT_W-1:0] rot_x,
    input  logic signed [QUAT_W-1:0] rot_y,
    input  logic signed [QUAT_W-1:0] rot_z,
    output shape_t                   cmd_out,
    output pos_vec_t                 pos_out,
    output size_vec_t                size_out,
    output abs_mat_t                 abs_out
);

    localparam logic signed [M_W-1:0] M_ONE = M_W'(1) << (2 * QUAT_FRAC_BITS);

    // stage 1
    logic signed [QPROD_W-1:0] xx_reg, yy_reg, zz_reg, xy_reg, wz_reg;
    logic signed [QPROD_W-1:0] xz_reg, wy_reg, yz_reg, wx_reg;
    shape_t                    cmd1_reg;
    pos_vec_t                  pos1_reg;
    size_vec_t                 size1_reg;

    // stage 2
    shape_t    cmd2_reg;
    pos_vec_t  pos2_reg;
    size_vec_t size2_reg;
    abs_mat_t  abs_reg;
    abs_mat_t  abs_next;

    logic signed [M_W-1:0] exx, eyy, ezz, exy, ewz, exz, ewy, eyz, ewx;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            xx_reg    <= QPROD_W'(rot_x) * QPROD_W'(rot_x);
            yy_reg    <= QPROD_W'(rot_y) * QPROD_W'(rot_y);
            zz_reg    <= QPROD_W'(rot_z) * QPROD_W'(rot_z);
            xy_reg    <= QPROD_W'(rot_x) * QPROD_W'(rot_y);
            wz_reg    <= QPROD_W'(rot_w) * QPROD_W'(rot_z);
            xz_reg    <= QPROD_W'(rot_x) * QPROD_W'(rot_z);
            wy_reg    <= QPROD_W'(rot_w) * QPROD_W'(rot_y);
            yz_reg    <= QPROD_W'(rot_y) * QPROD_W'(rot_z);
            wx_reg    <= QPROD_W'(rot_w) * QPROD_W'(rot_x);
            cmd1_reg  <= cmd_in;
            pos1_reg  <= pos_in;
            size1_reg <= size_in;
        end
        if (adv[1]) begin
            abs_reg   <= abs_next;
            cmd2_reg  <= cmd1_reg;
            pos2_reg  <= pos1_reg;
            size2_reg <= size1_reg;
        end
    end

    always_comb begin
        exx = M_W'(xx_reg);
        eyy = M_W'(yy_reg);
        ezz = M_W'(zz_reg);
        exy = M_W'(xy_reg);
        ewz = M_W'(wz_reg);
        exz = M_W'(xz_reg);
        ewy = M_W'(wy_reg);
        eyz = M_W'(yz_reg);
        ewx = M_W'(wx_reg);

        abs_next[0][0] = abs_round(M_ONE - ((eyy + ezz) <<< 1));
        abs_next[0][1] = abs_round((exy - ewz) <<< 1);
        abs_next[0][2] = abs_round((exz + ewy) <<< 1);
        abs_next[1][0] = abs_round((exy + ewz) <<< 1);
        abs_next[1][1] = abs_round(M_ONE - ((exx + ezz) <<< 1));
        abs_next[1][2] = abs_round((eyz - ewx) <<< 1);
        abs_next[2][0] = abs_round((exz - ewy) <<< 1);
        abs_next[2][1] = abs_round((eyz + ewx) <<< 1);
        abs_next[2][2] = abs_round(M_ONE - ((exx + eyy) <<< 1));
    end

    assign cmd_out  = cmd2_reg;
    assign pos_out  = pos2_reg;
    assign size_out = size2_reg;
    assign abs_out  = abs_reg;

endmodule

/* sv/sbb_ext.sv */
// ============================================================================
// sbb_ext: extent stages
// Stage 3 multiplies each rounded |Rij| by its size, stage 4 reduces the
// products to one half-extent per axis according to the shape type.
// ============================================================================
module sbb_ext
    import sbb_pkg::*;
(
    input  logic      aclk,
    input  logic [1:0] adv,       // stage advance: [0] stage 3, [1] stage 4
    input  shape_t    cmd_in,
    input  pos_vec_t  pos_in,
    input  size_vec_t size_in,
    input  abs_mat_t  abs_in,
    output shape_t    cmd_out,
    output pos_vec_t  pos_out,
    output ext_vec_t  ext_out
);

    // stage 3
    prod_mat_t           prod_reg;
    shape_t              cmd3_reg;
    pos_vec_t            pos3_reg;
    logic [SIZE_W-1:0]   rad3_reg;

    // stage 4
    shape_t   cmd4_reg;
    pos_vec_t pos4_reg;
    ext_vec_t ext_reg;
    ext_vec_t ext_next;

    logic [2:0][SUM_W-1:0]      box_sum;
    logic [2:0][PROD_W:0]       cap_sum;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= PROD_W'(abs_in[i][j]) * PROD_W'(size_in[j]);
                end
            end
            cmd3_reg <= cmd_in;
            pos3_reg <= pos_in;
            rad3_reg <= size_in[0];
        end
        if (adv[1]) begin
            ext_reg  <= ext_next;
            cmd4_reg <= cmd3_reg;
            pos4_reg <= pos3_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            box_sum[i] = SUM_W'(prod_reg[i][0]) + SUM_W'(prod_reg[i][1])
                       + SUM_W'(prod_reg[i][2]) + (SUM_W'(1) << (QUAT_FRAC_BITS - 1));
            // capsule: halve the height term with one extra bit of shift
            cap_sum[i] = (PROD_W + 1)'(prod_reg[i][1]) + ((PROD_W + 1)'(1) << QUAT_FRAC_BITS);
            case (cmd3_reg)
                SHAPE_SPHERE: begin
                    ext_next[i] = EXT_W'(rad3_reg);
                end
                SHAPE_BOX: begin
                    ext_next[i] = box_sum[i][SUM_W-1:QUAT_FRAC_BITS];
                end
                SHAPE_CAPSULE: begin
                    ext_next[i] = EXT_W'(cap_sum[i][PROD_W:QUAT_FRAC_BITS+1])
                                + EXT_W'(rad3_reg);
                end
                default: begin
                    ext_next[i] = '0;
                end
            endcase
        end
    end

    assign cmd_out = cmd4_reg;
    assign pos_out = pos4_reg;
    assign ext_out = ext_reg;

endmodule

/* sv/sbb_corner.sv */
// ============================================================================
// sbb_corner: corner stage
// Stage 5 forms position minus and plus the extent, saturates both corners
// and clears the box for the unsupported shape type.
// ============================================================================
module sbb_corner
    import sbb_pkg::*;
(
    input  logic     aclk,
    input  logic     adv,
    input  shape_t   cmd_in,
    input  pos_vec_t pos_in,
    input  ext_vec_t ext_in,
    output pos_vec_t min_out,
    output pos_vec_t max_out
);

    pos_vec_t min_reg, min_next;
    pos_vec_t max_reg, max_next;

    logic signed [2:0][CORNER_W-1:0] lo, hi;
    logic signed [CORNER_W-1:0]      pos_w, ext_w;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_w = CORNER_W'($signed(pos_in[i]));
            ext_w = $signed(CORNER_W'(ext_in[i]));
            lo[i] = pos_w - ext_w;
            hi[i] = pos_w + ext_w;
            if (cmd_in == SHAPE_OTHER) begin
                min_next[i] = '0;
                max_next[i] = '0;
            end else begin
                min_next[i] = sat_pos(lo[i]);
                max_next[i] = sat_pos(hi[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign min_out = min_reg;
    assign max_out = max_reg;

endmodule

/* sv/shape_bounding_box.sv */
// ============================================================================
// shape_bounding_box: axis-aligned bounding box of one oriented shape
// Five-stage pipeline from shape description to min/max corners.
// ============================================================================
// Usage:
//   The s_axis channel takes one shape per transfer: the type code on
//   s_axis_tuser, the position, quaternion and sizes packed in s_axis_tdata.
//   The m_axis channel gives one box per shape, min corner then max corner,
//   in the order the shapes came in.
//   Stages, in order: quaternion products, matrix rounding, size products,
//   extent reduction, corner saturation, one register stage each.
//   Throughput: one shape per cycle while m_axis_tready is high; every stage
//   holds a valid bit and advances whenever the stage after it is empty or
//   advancing.
//   Stall: when m_axis_tready is low the finished box holds on m_axis and
//   earlier stages keep filling their empty slots; s_axis_tready drops only
//   once all five stages hold an item. Nothing is dropped or repeated.
//   Reset: aresetn low for one clock empties the pipeline; payload registers
//   keep stale data, which is never shown because the valid bits are clear.
//   Shape type 3 returns an all-zero box; corners saturate to 32 bits.
// ============================================================================
module shape_bounding_box
    import sbb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [111:96] rot_w,
    // [127:112] rot_x, [143:128] rot_y, [159:144] rot_z, [190:160] size_a,
    // [221:191] size_b, [252:222] size_c, [255:253] zero
    input  logic [255:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] min_x, [63:32] min_y, [95:64] min_z,
    // [127:96] max_x, [159:128] max_y, [191:160] max_z
    output logic [191:0] m_axis_tdata
);

    // ------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------
    shape_t    in_cmd;
    pos_vec_t  in_pos;
    size_vec_t in_size;

    assign in_cmd     = shape_t'(s_axis_tuser);
    assign in_pos[0]  = s_axis_tdata[31:0];
    assign in_pos[1]  = s_axis_tdata[63:32];
    assign in_pos[2]  = s_axis_tdata[95:64];
    assign in_size[0] = s_axis_tdata[190:160];
    assign in_size[1] = s_axis_tdata[221:191];
    assign in_size[2] = s_axis_tdata[252:222];

    // ------------------------------------------------------------------
    // Pipeline control: one valid bit per stage, advance when the slot
    // ahead is free or moving on
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] adv;

    always_comb begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
                vld_next[k] = (k == 0) ? s_axis_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
            end else begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    shape_t    rot_cmd, ext_cmd;
    pos_vec_t  rot_pos, ext_pos;
    size_vec_t rot_size;
    abs_mat_t  rot_abs;
    ext_vec_t  ext_val;
    pos_vec_t  box_min, box_max;

    sbb_rot u_rot (
        .aclk     (aclk),
        .adv      (adv[1:0]),
        .cmd_in   (in_cmd),
        .pos_in   (in_pos),
        .size_in  (in_size),
        .rot_w    ($signed(s_axis_tdata[111:96])),
        .rot_x    ($signed(s_axis_tdata[127:112])),
        .rot_y    ($signed(s_axis_tdata[143:128])),
        .rot_z    ($signed(s_axis_tdata[159:144])),
        .cmd_out  (rot_cmd),
        .pos_out  (rot_pos),
        .size_out (rot_size),
        .abs_out  (rot_abs)
    );

    sbb_ext u_ext (
        .aclk    (aclk),
        .adv     (adv[3:2]),
        .cmd_in  (rot_cmd),
        .pos_in  (rot_pos),
        .size_in (rot_size),
        .abs_in  (rot_abs),
        .cmd_out (ext_cmd),
        .pos_out (ext_pos),
        .ext_out (ext_val)
    );

    sbb_corner u_corner (
        .aclk    (aclk),
        .adv     (adv[4]),
        .cmd_in  (ext_cmd),
        .pos_in  (ext_pos),
        .ext_in  (ext_val),
        .min_out (box_min),
        .max_out (box_max)
    );

    // Pack: min x, y, z then max x, y, z from the low bits up
    assign m_axis_tdata = {box_max[2], box_max[1], box_max[0],
                           box_min[2], box_min[1], box_min[0]};

endmodule

/* sv/sbb_checker.sv */
// ============================================================================
// sbb_checker: port-level checks for the shape bounding box
// Watches the stream ports for reset, back-pressure and min/max corner order.
// ============================================================================
module sbb_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata
);

    // A stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

    // Reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
    else $error("result shown right after reset");

    // Input side stalls only when the output stage is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with a free output stage");

    // Every box has min no greater than max on each axis
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[31:0])  <= $signed(m_axis_tdata[127:96])) &&
            ($signed(m_axis_tdata[63:32]) <= $signed(m_axis_tdata[159:128])) &&
            ($signed(m_axis_tdata[95:64]) <= $signed(m_axis_tdata[191:160])))
    else $error("box min corner above max corner");

endmodule

bind shape_bounding_box sbb_checker u_sbb_checker (.*);

/* tb/sv/tb.sv */
// ============================================================================
// tb: self-checking bench for shape_bounding_box
// Streams directed and random shapes (spheres, boxes, capsules, other codes)
// into the block, predicts each bounding box in 64-bit integer arithmetic and
// checks every result transfer field by field, in order. Both sides idle in
// random bursts; one long result stall fills the pipeline and one sender
// pause drains it.
// ============================================================================
module tb;
    import sbb_pkg::*;

    localparam int RANDOM_SHAPES = 700;
    localparam int CALM_TAIL     = 100;   // last transfers run with no idling
    localparam int HOLD_CYCLES   = 64;    // long result stall
    localparam int HOLD_AT       = 250;
    localparam int DRAIN_AT      = 450;
    localparam int DRAIN_CYCLES  = 16;    // pipeline depth plus margin
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_REPORTS   = 10;

    // One shape as the input channel carries it
    typedef struct {
        shape_t             kind;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] qw, qx, qy, qz;
        logic [30:0]        sa, sb, sc;
    } shape_item_t;

    // One box as the result channel carries it: min x, y, z then max x, y, z
    typedef logic [5:0][31:0] box_t;

    // ------------------------------------------------------------------------
    // Box predictor and in-order checker
    // ------------------------------------------------------------------------
    class box_scoreboard;
        box_t pending_boxes[$];
        int   mismatches;
        int   strays;

        function new();
            mismatches = 0;
            strays     = 0;
        endfunction

        static function logic [31:0] clamp_pos(longint v);
            if (v > 64'sd2147483647) begin
                return 32'h7FFF_FFFF;
            end else if (v < -64'sd2147483648) begin
                return 32'h8000_0000;
            end
            return v[31:0];
        endfunction

        // |m| rounded half up to the quaternion fraction
        static function longint abs_rnd(longint m);
            longint mag;
            mag = (m < 0) ? -m : m;
            return (mag + (64'sd1 <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
        endfunction

        static function box_t bounds_of(shape_item_t s);
            longint p[3], sz[3], e[3], m[3][3], a[3][3];
            longint w, x, y, z, one, acc;
            box_t   b;
            b = '0;
            if (s.kind == SHAPE_OTHER) begin
                return b;
            end
            p[0] = longint'(s.px);
            p[1] = longint'(s.py);
            p[2] = longint'(s.pz);
            sz[0] = longint'({33'd0, s.sa});
            sz[1] = longint'({33'd0, s.sb});
            sz[2] = longint'({33'd0, s.sc});
            w = longint'(s.qw);
            x = longint'(s.qx);
            y = longint'(s.qy);
            z = longint'(s.qz);
            one = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
            // rotation matrix at twice the quaternion fraction, no normalizing
            m[0][0] = one - 2 * (y * y + z * z);
            m[0][1] = 2 * (x * y - w * z);
            m[0][2] = 2 * (x * z + w * y);
            m[1][0] = 2 * (x * y + w * z);
            m[1][1] = one - 2 * (x * x + z * z);
            m[1][2] = 2 * (y * z - w * x);
            m[2][0] = 2 * (x * z - w * y);
            m[2][1] = 2 * (y * z + w * x);
            m[2][2] = one - 2 * (x * x + y * y);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    a[i][j] = abs_rnd(m[i][j]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                case (s.kind)
                    SHAPE_SPHERE: begin
                        e[i] = sz[0];
                    end
                    SHAPE_BOX: begin
                        acc  = a[i][0] * sz[0] + a[i][1] * sz[1] + a[i][2] * sz[2];
                        e[i] = (acc + (64'sd1 <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
                    end
                    default: begin
                        // capsule: half height along rotated local y, plus radius
                        acc  = a[i][1] * sz[1];
                        e[i] = ((acc + (64'sd1 <<< QUAT_FRAC_BITS)) >>> (QUAT_FRAC_BITS + 1))
                               + sz[0];
                    end
                endcase
                b[i]     = clamp_pos(p[i] - e[i]);
                b[3 + i] = clamp_pos(p[i] + e[i]);
            end
            return b;
        endfunction

        static function string field_name(int f);
            case (f)
                0: return "min_x";
                1: return "min_y";
                2: return "min_z";
                3: return "max_x";
                4: return "max_y";
                default: return "max_z";
            endcase
        endfunction

        function void note_shape(shape_item_t s);
            pending_boxes.push_back(bounds_of(s));
        endfunction

        function void check_box(box_t got);
            box_t want;
            if (pending_boxes.size() == 0) begin
                strays++;
                if (mismatches + strays <= MAX_REPORTS) begin
                    $display("result with nothing pending: %h", got);
                end
                return;
            end
            want = pending_boxes.pop_front();
            for (int f = 0; f < 6; f++) begin
                if (got[f] !== want[f]) begin
                    mismatches++;
                    if (mismatches + strays <= MAX_REPORTS) begin
                        $display("%s mismatch: expected %h, got %h",
                                 field_name(f), want[f], got[f]);
                    end
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [31:0] pos_x ... [252:222] size_c, [255:253] zero
    logic [255:0] s_axis_tdata;
    // [1:0] cmd
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [31:0] min_x ... [191:160] max_z
    logic [191:0] m_axis_tdata;

    shape_bounding_box uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #4 aclk = ~aclk;
        end
    end

    box_scoreboard  sb = new();
    shape_item_t    offered;       // shape currently on the input channel
    shape_item_t    shape_list[$];
    bit             calm;          // no idling on either side
    bit             hold_req;      // ask the receiver for a long stall

    // Record both handshakes at the same edge so ordering never depends on
    // which process wakes first.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_shape(offered);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_box(m_axis_tdata);
            end
        end
    end

    // Hard stop if the block hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shape construction
    // ------------------------------------------------------------------------
    function automatic shape_item_t mk_shape(shape_t k, logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz, logic [15:0] qw,
                                             logic [15:0] qx, logic [15:0] qy,
                                             logic [15:0] qz, logic [30:0] sa,
                                             logic [30:0] sb_, logic [30:0] sc);
        shape_item_t s;
        s.kind = k;
        s.px = px;  s.py = py;  s.pz = pz;
        s.qw = qw;  s.qx = qx;  s.qy = qy;  s.qz = qz;
        s.sa = sa;  s.sb = sb_; s.sc = sc;
        return s;
    endfunction

    function automatic logic [31:0] rand_pos();
        int t;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                t = $urandom_range(0, 2 << 20);
                t -= (1 << 20);
                return t;
            end
            2: return 32'h7FFF_FFFF - $urandom_range(0, 1 << 24);
            default: return 32'h8000_0000 + $urandom_range(0, 1 << 24);
        endcase
    endfunction

    // Sizes spread over all magnitudes so every bit toggles
    function automatic logic [30:0] rand_size();
        logic [31:0] mask;
        mask = (32'd1 << $urandom_range(1, 31)) - 32'd1;
        return 31'($urandom & mask);
    endfunction

    function automatic logic [15:0] sparse_q();
        case ($urandom_range(0, 6))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd11585;
            3: return -16'sd11585;
            default: return 16'sd0;
        endcase
    endfunction

    function automatic shape_item_t rand_shape();
        shape_item_t s;
        int          v[4];
        real         nrm;
        int          sel;
        sel = $urandom_range(0, 9);
        s.kind = (sel < 2) ? SHAPE_SPHERE : (sel < 6) ? SHAPE_BOX :
                 (sel < 9) ? SHAPE_CAPSULE : SHAPE_OTHER;
        s.px = rand_pos();
        s.py = rand_pos();
        s.pz = rand_pos();
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                // near-unit orientation from a random normalized 4-vector
                for (int i = 0; i < 4; i++) begin
                    v[i] = $urandom_range(0, 2000);
                    v[i] -= 1000;
                end
                nrm = $sqrt(real'(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]));
                if (nrm < 1.0) begin
                    v = '{1, 0, 0, 0};
                    nrm = 1.0;
                end
                s.qw = 16'($rtoi(16384.0 * v[0] / nrm));
                s.qx = 16'($rtoi(16384.0 * v[1] / nrm));
                s.qy = 16'($rtoi(16384.0 * v[2] / nrm));
                s.qz = 16'($rtoi(16384.0 * v[3] / nrm));
            end
            3: begin
                s.qw = sparse_q();
                s.qx = sparse_q();
                s.qy = sparse_q();
                s.qz = sparse_q();
            end
            default: begin
                // arbitrary, generally non-unit
                for (int i = 0; i < 4; i++) begin
                    v[i] = $urandom_range(0, 32768);
                    v[i] -= 16384;
                end
                s.qw = 16'(v[0]);
                s.qx = 16'(v[1]);
                s.qy = 16'(v[2]);
                s.qz = 16'(v[3]);
            end
        endcase
        s.sa = rand_size();
        s.sb = rand_size();
        s.sc = rand_size();
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Offer one shape from a falling edge and hold it until the transfer.
    task automatic send_shape(shape_item_t s);
        offered       = s;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= s.kind;
        s_axis_tdata  <= {3'b000, s.sc, s.sb, s.sa, s.qz, s.qy, s.qx, s.qw,
                          s.pz, s.py, s.px};
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (sb.pending_boxes.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // Receiver: random ready bursts, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int total;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = SHAPE_SPHERE;
        calm          = 1'b0;
        hold_req      = 1'b0;

        // Directed shapes: field extremes, every type, rounding and saturation
        // sphere: plain, saturate high, saturate low, quaternion and extra sizes ignored
        shape_list.push_back(mk_shape(SHAPE_SPHERE, 0, 0, 0, 16384, 0, 0, 0,
                                      31'h10000, 0, 0));
        shape_list.push_back(mk_shape(SHAPE_SPHERE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 0, 0, 0, 0, 31'h7FFF_FFFF, 0, 0));
        shape_list.push_back(mk_shape(SHAPE_SPHERE, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 0, 0, 0, 0, 31'h7FFF_FFFF, 0, 0));
        shape_list.push_back(mk_shape(SHAPE_SPHERE, 32'h0001_2345, 32'hFFFF_0000, 5,
                                      -16384, 16384, -16384, 16384, 31'h3,
                                      31'h7FFF_FFFF, 31'h7FFF_FFFF));
        // box: identity, quarter turn about z, non-unit and negative quaternions
        shape_list.push_back(mk_shape(SHAPE_BOX, 0, 0, 0, 16384, 0, 0, 0,
                                      31'h10000, 31'h20000, 31'h30000));
        shape_list.push_back(mk_shape(SHAPE_BOX, 32'h0010_0000, 0, 0, 11585, 0, 0, 11585,
                                      31'h10000, 31'h20000, 31'h30000));
        shape_list.push_back(mk_shape(SHAPE_BOX, 0, 0, 0, 16384, 16384, 16384, 16384,
                                      31'h1_0000, 31'h1_8000, 31'h2_0000));
        shape_list.push_back(mk_shape(SHAPE_BOX, 0, 0, 0, -16384, -16384, -16384, -16384,
                                      31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        shape_list.push_back(mk_shape(SHAPE_BOX, 0, 0, 0, 16384, 0, 0, 0,
                                      31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        shape_list.push_back(mk_shape(SHAPE_BOX, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                                      -16384, 0, 0, 0, 31'h1, 31'h1, 31'h1));
        shape_list.push_back(mk_shape(SHAPE_BOX, 0, 0, 0, 0, 0, 0, 0,
                                      31'h4000, 31'h4000, 31'h4000));
        shape_list.push_back(mk_shape(SHAPE_BOX, 32'h0000_8000, 0, 0, 16384, 1, -1, 1,
                                      31'h7, 31'h2001, 31'h1FFF));
        shape_list.push_back(mk_shape(SHAPE_BOX, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 11585, 11585, 0, 0, 0, 0, 0));
        // capsule: identity, quarter turn about x, saturation, odd height rounding
        shape_list.push_back(mk_shape(SHAPE_CAPSULE, 0, 0, 0, 16384, 0, 0, 0,
                                      31'h10000, 31'h40000, 0));
        shape_list.push_back(mk_shape(SHAPE_CAPSULE, 0, 32'h0001_0000, 0, 11585, 11585, 0, 0,
                                      31'h10000, 31'h40000, 0));
        shape_list.push_back(mk_shape(SHAPE_CAPSULE, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'h7FFF_FFFF, 16384, 16384, 16384, 16384,
                                      31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        shape_list.push_back(mk_shape(SHAPE_CAPSULE, 0, 0, 0, 11585, 0, 11585, 0,
                                      31'h0, 31'h1, 31'h7FFF_FFFF));
        shape_list.push_back(mk_shape(SHAPE_CAPSULE, 0, 0, 0, 0, 0, 0, 16384,
                                      31'h3, 31'h3, 31'h5555_5555));
        shape_list.push_back(mk_shape(SHAPE_CAPSULE, 0, 0, 0, -16384, 16384, -16384, 16384,
                                      31'h7FFF_FFFF, 31'h7FFF_FFFF, 0));
        // other type code: all-zero box whatever the fields hold
        shape_list.push_back(mk_shape(SHAPE_OTHER, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'hFFFF_FFFF, -16384, 16384, -16384, 16384,
                                      31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        shape_list.push_back(mk_shape(SHAPE_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        for (int i = 0; i < RANDOM_SHAPES; i++) begin
            shape_list.push_back(rand_shape());
        end
        total = shape_list.size();

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int n = 0; n < total; n++) begin
            if (n == total - CALM_TAIL) begin
                calm = 1'b1;
            end
            if (n == HOLD_AT) begin
                // keep offering while results back up, so input ready drops
                hold_req = 1'b1;
            end
            if (n == DRAIN_AT) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end else if (!calm && !hold_req && $urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end
            send_shape(shape_list[n]);
        end
        s_axis_tvalid <= 1'b0;

        // Let the pipeline empty, then watch for strays
        while (sb.pending_boxes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.strays == 0 && sb.pending_boxes.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/sbb_pkg.sv
sv/sbb_rot.sv
sv/sbb_ext.sv
sv/sbb_corner.sv
sv/shape_bounding_box.sv
sv/sbb_checker.sv
tb/sv/tb.sv
